// ----- rtl/tga_truecolor_rle_decoder_defines.svh -----
// Assertion macros shared by the TGA decoder RTL.
`ifndef TGA_TRUECOLOR_RLE_DECODER_DEFINES_SVH
`define TGA_TRUECOLOR_RLE_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/tga_rle_pkg.sv -----
// Types and constants shared by the TGA true-color RLE decoder.
package tga_rle_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ERR_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    // header byte offsets
    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_TYPE      = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_DEPTH     = 5'd16;
    localparam logic [4:0] HB_FLAGS     = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // flag bits of the descriptor byte
    localparam int FLAG_TOP_DOWN_BIT   = 5;
    localparam int FLAG_RIGHT_LEFT_BIT = 4;
    // repeat bit of a packet byte
    localparam int PKT_REPEAT_BIT      = 7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_count;
        logic [15:0] dest_row;
        logic [15:0] dest_col;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  error_code;
        logic        image_done;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  error_code;
        logic        image_done;
        logic        top_down;
        logic        right_to_left;
    } t_job;

endpackage

// ----- rtl/tga_rle_queue.sv -----
// Small FIFO between the byte parser and the run placer.
module tga_rle_queue #(
    parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tga_rle_pkg::t_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output tga_rle_pkg::t_job o_job
);
    import tga_rle_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tga_rle_front.sv -----
// Byte parser: header checks, ID skip, packet and pixel assembly, run classification.
module tga_rle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tga_rle_pkg::t_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_push,
    output tga_rle_pkg::t_job o_job,
    input  logic              i_full
);
    import tga_rle_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_WAIT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_id_remaining, n_id_remaining;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_depth, n_depth;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_area;
    logic        r_rle, n_rle;
    logic        r_four, n_four;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic [7:0]  r_packet_left, n_packet_left;
    logic        r_repeat, n_repeat;
    logic [1:0]  r_comp, n_comp;
    logic [7:0]  r_color [4];
    logic [7:0]  n_color [4];

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        err_hit;
    logic [2:0]  err_code;
    logic [7:0]  run_n;
    logic [7:0]  pkt_n;
    logic [7:0]  pkt_left_next;
    logic        done;
    logic [1:0]  comp_last;
    t_phase      data_phase;
    t_job        job;
    logic        push;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign b          = i_in_data.byte_value;
    assign last       = i_in_data.last_byte;
    assign comp_last  = r_four ? 2'd3 : 2'd2;
    assign data_phase = r_rle ? PH_PACKET : PH_PIXEL;
    assign o_push     = push;
    assign o_job      = job;

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_id_remaining = r_id_remaining;
        n_type         = r_type;
        n_depth        = r_depth;
        n_width        = r_width;
        n_height       = r_height;
        n_rle          = r_rle;
        n_four         = r_four;
        n_pixels_left  = r_pixels_left;
        n_packet_left  = r_packet_left;
        n_repeat       = r_repeat;
        n_comp         = r_comp;
        n_color        = r_color;
        err_hit        = 1'b0;
        err_code       = ERR_NONE;
        run_n          = 8'd1;
        pkt_n          = 8'd1;
        pkt_left_next  = r_packet_left;
        done           = 1'b0;
        job            = '0;
        push           = 1'b0;

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    case (r_byte_count)
                        HB_ID_LEN:    n_id_remaining = b;
                        HB_TYPE:      n_type = b;
                        HB_WIDTH_LO:  n_width = {8'd0, b};
                        HB_WIDTH_HI:  n_width = {b, r_width[7:0]};
                        HB_HEIGHT_LO: n_height = {8'd0, b};
                        HB_HEIGHT_HI: n_height = {b, r_height[7:0]};
                        HB_DEPTH:     n_depth = b;
                        default:      ;
                    endcase
                    if (last) begin
                        err_hit  = 1'b1;
                        err_code = ERR_SHORT;
                    end else if (r_byte_count != HB_FLAGS) begin
                        n_byte_count = r_byte_count + 5'd1;
                    end else begin
                        n_byte_count = '0;
                        if (r_type != TYPE_RAW && r_type != TYPE_RLE) begin
                            err_hit  = 1'b1;
                            err_code = ERR_BAD_TYPE;
                        end else if (r_width == '0 || r_height == '0 ||
                                     (r_depth != DEPTH_24 && r_depth != DEPTH_32)) begin
                            err_hit  = 1'b1;
                            err_code = ERR_BAD_SIZE;
                        end else begin
                            n_rle         = (r_type == TYPE_RLE);
                            n_four        = (r_depth == DEPTH_32);
                            n_pixels_left = r_area;
                            n_packet_left = '0;
                            n_repeat      = 1'b0;
                            n_comp        = '0;
                            if (r_id_remaining != '0) begin
                                n_phase = PH_IDSKIP;
                            end else if (r_type == TYPE_RLE) begin
                                n_phase = PH_PACKET;
                            end else begin
                                n_phase = PH_PIXEL;
                            end
                            push              = 1'b1;
                            job.kind          = KIND_HEADER;
                            job.image_width   = r_width;
                            job.image_height  = r_height;
                            job.top_down      = b[FLAG_TOP_DOWN_BIT];
                            job.right_to_left = b[FLAG_RIGHT_LEFT_BIT];
                        end
                    end
                end
                PH_IDSKIP: begin
                    if (last) begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end else begin
                        n_id_remaining = r_id_remaining - 8'd1;
                        if (r_id_remaining == 8'd1) begin
                            n_phase = data_phase;
                        end
                    end
                end
                PH_PACKET: begin
                    pkt_n = {1'b0, b[6:0]} + 8'd1;
                    if (r_pixels_left < 32'(pkt_n)) begin
                        pkt_n = r_pixels_left[7:0];
                    end
                    if (last) begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end else begin
                        n_packet_left = pkt_n;
                        n_repeat      = b[PKT_REPEAT_BIT];
                        n_comp        = '0;
                        n_phase       = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    n_color[r_comp] = b;
                    if (r_comp != comp_last) begin
                        n_comp = r_comp + 2'd1;
                        if (last) begin
                            err_hit  = 1'b1;
                            err_code = ERR_TRUNCATED;
                        end
                    end else begin
                        n_comp = '0;
                        run_n  = (r_rle && r_repeat) ? r_packet_left : 8'd1;
                        if (run_n == '0) begin
                            run_n = 8'd1;
                        end
                        if (r_pixels_left < 32'(run_n)) begin
                            run_n = r_pixels_left[7:0];
                        end
                        done = (r_pixels_left == 32'(run_n));
                        if (last && !done) begin
                            err_hit  = 1'b1;
                            err_code = ERR_TRUNCATED;
                        end else begin
                            push           = 1'b1;
                            job.kind       = KIND_RUN;
                            job.red        = n_color[2];
                            job.green      = n_color[1];
                            job.blue       = n_color[0];
                            job.alpha      = r_four ? n_color[3] : ALPHA_OPAQUE;
                            job.run_count  = run_n;
                            job.image_done = done;
                            n_pixels_left  = r_pixels_left - 32'(run_n);
                            if (r_rle) begin
                                pkt_left_next = r_repeat ? 8'd0 : r_packet_left - 8'd1;
                                n_packet_left = pkt_left_next;
                                if (pkt_left_next == '0) begin
                                    n_phase = PH_PACKET;
                                end
                            end
                            if (done) begin
                                n_phase = last ? PH_HEADER : PH_WAIT;
                            end
                        end
                    end
                end
                default: begin
                    // image finished or failed: drop bytes until end of file
                    if (last) begin
                        n_phase      = PH_HEADER;
                        n_byte_count = '0;
                        n_comp       = '0;
                    end
                end
            endcase

            if (err_hit) begin
                push           = 1'b1;
                job            = '0;
                job.kind       = KIND_ERROR;
                job.error_code = err_code;
                n_phase        = last ? PH_HEADER : PH_WAIT;
                if (last) begin
                    n_byte_count = '0;
                    n_comp       = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_comp       <= '0;
        end else begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_comp         <= n_comp;
            r_id_remaining <= n_id_remaining;
            r_type         <= n_type;
            r_depth        <= n_depth;
            r_width        <= n_width;
            r_height       <= n_height;
            r_rle          <= n_rle;
            r_four         <= n_four;
            r_pixels_left  <= n_pixels_left;
            r_packet_left  <= n_packet_left;
            r_repeat       <= n_repeat;
            r_color        <= n_color;
        end
    end

    // pixel total, ready well before the flags byte
    always_ff @(posedge i_clk) begin
        r_area <= {16'd0, r_width} * {16'd0, r_height};
    end

endmodule

// ----- rtl/tga_rle_back.sv -----
// Run placer: maps source position to destination and advances it by each run.
module tga_rle_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tga_rle_pkg::t_job i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    output tga_rle_pkg::t_out o_out_data,
    input  logic              i_out_stall
);
    import tga_rle_pkg::*;

    typedef enum logic {
        BK_IDLE,
        BK_WRAP
    } t_bstate;

    t_bstate     r_state;
    logic        r_out_valid;
    t_out        r_out;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic        r_top_down;
    logic        r_right_to_left;
    logic [15:0] r_src_row;
    logic [15:0] r_src_col;
    logic [16:0] r_total;

    logic        out_free;
    logic        pop;
    logic [15:0] drow;
    logic [15:0] dcol;
    logic        wrap_ge;
    t_out        n_out;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign pop         = (r_state == BK_IDLE) && i_valid && out_free;
    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign drow    = r_top_down ? r_src_row : r_height - 16'd1 - r_src_row;
    assign dcol    = r_right_to_left ? r_width - 16'd1 - r_src_col : r_src_col;
    assign wrap_ge = (r_total >= {1'b0, r_width});

    always_comb begin
        n_out              = '0;
        n_out.kind         = i_job.kind;
        n_out.red          = i_job.red;
        n_out.green        = i_job.green;
        n_out.blue         = i_job.blue;
        n_out.alpha        = i_job.alpha;
        n_out.run_count    = i_job.run_count;
        n_out.image_width  = i_job.image_width;
        n_out.image_height = i_job.image_height;
        n_out.error_code   = i_job.error_code;
        n_out.image_done   = i_job.image_done;
        if (i_job.kind == KIND_RUN) begin
            n_out.dest_row = drow;
            n_out.dest_col = dcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
                case (i_job.kind)
                    KIND_HEADER: begin
                        r_width         <= i_job.image_width;
                        r_height        <= i_job.image_height;
                        r_top_down      <= i_job.top_down;
                        r_right_to_left <= i_job.right_to_left;
                        r_src_row       <= '0;
                        r_src_col       <= '0;
                    end
                    KIND_RUN: begin
                        r_total <= {1'b0, r_src_col} + {9'd0, i_job.run_count};
                        r_state <= BK_WRAP;
                    end
                    default: ;
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // one row of wrap per cycle
            if (r_state == BK_WRAP) begin
                if (wrap_ge) begin
                    r_total   <= r_total - {1'b0, r_width};
                    r_src_row <= r_src_row + 16'd1;
                end else begin
                    r_src_col <= r_total[15:0];
                    r_state   <= BK_IDLE;
                end
            end
        end
    end

endmodule

// ----- rtl/tga_truecolor_rle_decoder.sv -----
// Top level of the TGA true-color RLE decoder: parser, item queue and run placer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_data  (byte_value, last_byte)
//  out     | from block| o_out_valid / i_out_stall | o_out_data (kind, color, run, ...)
//
// The parser takes one file byte per cycle while the queue has room; every byte,
// with or without a result, waits while the queue is full.
// The placer loads a run into the output register, then crosses the rows it spans
// one by one and finally stores the new column before it takes the next item.
// Header and error items need only the load.
// A held output stalls the placer, which in turn fills the queue.
// Synchronous active-low reset returns to the header phase with the queue empty;
// no clearing pass is needed.
`include "tga_truecolor_rle_decoder_defines.svh"

module tga_truecolor_rle_decoder #(
    parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tga_rle_pkg::t_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output tga_rle_pkg::t_out o_out_data,
    input  logic              i_out_stall
);
    import tga_rle_pkg::*;

    // front -> queue
    logic q_push;
    t_job q_in_job;
    logic q_full;
    // queue -> back
    logic q_pop;
    logic q_valid;
    t_job q_out_job;
    // result classes seen by the checks
    logic out_run;
    logic out_misc;
    logic out_no_pos;

    assign out_run    = o_out_valid && (o_out_data.kind == KIND_RUN);
    assign out_misc   = o_out_valid && (o_out_data.kind != KIND_RUN);
    assign out_no_pos = (o_out_data.dest_row == 16'd0) && (o_out_data.dest_col == 16'd0);

    // header parse, ID skip, packet decode, pixel assembly
    tga_rle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_job      (q_in_job),
        .i_full     (q_full)
    );

    // decouples the byte-rate parser from the multi-cycle placer
    tga_rle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // orientation mapping, row/column advance, output register
    tga_rle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (q_out_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // parser never writes into a full queue
    `TGA_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    // a pop without a push always leaves room
    `TGA_ASSERT_NEXT(a_pop_frees, i_clk, i_rst_n, q_pop && !q_push, !q_full)
    // runs always cover at least one pixel
    `TGA_ASSERT_IMP(a_run_nonzero, i_clk, i_rst_n, out_run, o_out_data.run_count != 8'd0)
    // header and error items carry no position
    `TGA_ASSERT_IMP(a_no_dest_misc, i_clk, i_rst_n, out_misc, out_no_pos)

endmodule

// ----- sim/tb.sv -----
// Testbench for the TGA true-color RLE decoder: byte-stream files in, checked runs out.
module tb;
    import tga_rle_pkg::*;

    // Parse states of the byte-level decode predictor.
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_IDSKIP,
        ST_PACKET,
        ST_PIXEL,
        ST_WAIT
    } t_parse_st;

    // Receiver back-pressure styles; one is picked for each stretch of cycles.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    localparam int RANDOM_BYTES = 1550; // input items for the whole run
    localparam int IDLE_LIMIT   = 5000; // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 300;  // longest run placement plus queue slack

    // Tracks the decoder byte by byte, keeps the results it owes, and checks them.
    class tga_result_board;
        t_parse_st   st;
        logic [4:0]  hdr_idx;
        logic [7:0]  id_left;
        logic        rle;
        logic [15:0] wid;
        logic [15:0] hgt;
        logic [7:0]  img_type;
        logic [7:0]  depth;
        logic        rgba;
        logic        top_down;
        logic        flip_x;
        logic [31:0] px_left;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  pkt_left;
        logic        pkt_rep;
        logic [1:0]  comp;
        logic [7:0]  bgra [4];
        t_out        results_due [$];
        int          failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            st       = ST_HEADER;
            hdr_idx  = '0;
            id_left  = '0;
            rle      = 1'b0;
            wid      = '0;
            hgt      = '0;
            img_type = '0;
            depth    = '0;
            rgba     = 1'b0;
            top_down = 1'b0;
            flip_x   = 1'b0;
            px_left  = '0;
            row      = '0;
            col      = '0;
            pkt_left = '0;
            pkt_rep  = 1'b0;
            comp     = '0;
            foreach (bgra[i]) bgra[i] = '0;
        endfunction

        // End of an image or an error: park until the file's last byte.
        function void close_file(bit last);
            if (last) clear();
            else st = ST_WAIT;
        endfunction

        function void push_error(logic [2:0] code, bit last);
            t_out r;
            r = '0;
            r.kind       = KIND_ERROR;
            r.error_code = code;
            results_due.push_back(r);
            close_file(last);
        endfunction

        function void note_byte(t_in item);
            logic [7:0]  b;
            logic        last;
            int unsigned n;
            int unsigned total;
            int unsigned ncomp;
            logic        done;
            t_out        r;
            b    = item.byte_value;
            last = item.last_byte;
            case (st)
                ST_HEADER: begin
                    case (hdr_idx)
                        HB_ID_LEN:    id_left = b;
                        HB_TYPE:      img_type = b;
                        HB_WIDTH_LO:  wid = {8'h00, b};
                        HB_WIDTH_HI:  wid = wid | {b, 8'h00};
                        HB_HEIGHT_LO: hgt = {8'h00, b};
                        HB_HEIGHT_HI: hgt = hgt | {b, 8'h00};
                        HB_DEPTH:     depth = b;
                        HB_FLAGS: begin
                            top_down = b[FLAG_TOP_DOWN_BIT];
                            flip_x   = b[FLAG_RIGHT_LEFT_BIT];
                        end
                        default: ;
                    endcase
                    // a file ending anywhere in the header is too short, whatever it says
                    if (last) begin
                        push_error(ERR_SHORT, 1'b1);
                    end else if (hdr_idx < HB_FLAGS) begin
                        hdr_idx = hdr_idx + 5'd1;
                    end else begin
                        hdr_idx = '0;
                        if (img_type != TYPE_RAW && img_type != TYPE_RLE) begin
                            push_error(ERR_BAD_TYPE, 1'b0);
                        end else if (wid == 0 || hgt == 0 ||
                                     (depth != DEPTH_24 && depth != DEPTH_32)) begin
                            push_error(ERR_BAD_SIZE, 1'b0);
                        end else begin
                            rle      = (img_type == TYPE_RLE);
                            rgba     = (depth == DEPTH_32);
                            px_left  = {16'h0000, wid} * {16'h0000, hgt};
                            row      = '0;
                            col      = '0;
                            pkt_left = '0;
                            pkt_rep  = 1'b0;
                            comp     = '0;
                            if (id_left != 0) st = ST_IDSKIP;
                            else st = rle ? ST_PACKET : ST_PIXEL;
                            r = '0;
                            r.kind         = KIND_HEADER;
                            r.image_width  = wid;
                            r.image_height = hgt;
                            results_due.push_back(r);
                        end
                    end
                end
                ST_IDSKIP: begin
                    if (last) begin
                        push_error(ERR_TRUNCATED, 1'b1);
                    end else begin
                        id_left = id_left - 8'd1;
                        if (id_left == 0) st = rle ? ST_PACKET : ST_PIXEL;
                    end
                end
                ST_PACKET: begin
                    if (last) begin
                        push_error(ERR_TRUNCATED, 1'b1);
                    end else begin
                        // oversize counts are clipped to what is left of the image
                        n = b[6:0] + 1;
                        if (n > px_left) n = px_left;
                        pkt_left = 8'(n);
                        pkt_rep  = b[PKT_REPEAT_BIT];
                        comp     = '0;
                        st       = ST_PIXEL;
                    end
                end
                ST_PIXEL: begin
                    ncomp = rgba ? 4 : 3;
                    bgra[comp] = b;
                    if (comp + 1 < ncomp) begin
                        comp = comp + 2'd1;
                        if (last) push_error(ERR_TRUNCATED, 1'b1);
                    end else begin
                        comp = '0;
                        n = (rle && pkt_rep) ? pkt_left : 1;
                        if (n == 0) n = 1;
                        if (n > px_left) n = px_left;
                        done = (px_left == n);
                        // truncation replaces the run this byte would have finished
                        if (last && !done) begin
                            push_error(ERR_TRUNCATED, 1'b1);
                        end else begin
                            r = '0;
                            r.kind       = KIND_RUN;
                            r.red        = bgra[2];
                            r.green      = bgra[1];
                            r.blue       = bgra[0];
                            r.alpha      = rgba ? bgra[3] : ALPHA_OPAQUE;
                            r.run_count  = 8'(n);
                            r.dest_row   = top_down ? row : hgt - 16'd1 - row;
                            r.dest_col   = flip_x ? wid - 16'd1 - col : col;
                            r.image_done = done;
                            results_due.push_back(r);
                            px_left = px_left - n;
                            // runs may wrap across several rows
                            total = col + n;
                            row   = row + 16'(total / wid);
                            col   = 16'(total % wid);
                            if (rle) begin
                                pkt_left = pkt_rep ? 8'd0 : pkt_left - 8'd1;
                                if (pkt_left == 0) st = ST_PACKET;
                            end
                            if (done) close_file(last);
                        end
                    end
                end
                default: begin
                    if (last) clear();
                end
            endcase
        endfunction

        function string show(t_out r);
            return $sformatf({"kind %0d rgba %02h/%02h/%02h/%02h n %0d at (%0d,%0d) ",
                              "size %0dx%0d err %0d done %0b"},
                             r.kind, r.red, r.green, r.blue, r.alpha, r.run_count,
                             r.dest_row, r.dest_col, r.image_width, r.image_height,
                             r.error_code, r.image_done);
        endfunction

        function void flag_fail(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_result(t_out got);
            t_out  want;
            string bad;
            bad = "";
            if (results_due.size() == 0) begin
                flag_fail($sformatf("tb: result with nothing pending: %s", show(got)));
                return;
            end
            want = results_due.pop_front();
            if (got.kind !== want.kind)                 bad = {bad, " kind"};
            if (got.red !== want.red)                   bad = {bad, " red"};
            if (got.green !== want.green)               bad = {bad, " green"};
            if (got.blue !== want.blue)                 bad = {bad, " blue"};
            if (got.alpha !== want.alpha)               bad = {bad, " alpha"};
            if (got.run_count !== want.run_count)       bad = {bad, " run_count"};
            if (got.dest_row !== want.dest_row)         bad = {bad, " dest_row"};
            if (got.dest_col !== want.dest_col)         bad = {bad, " dest_col"};
            if (got.image_width !== want.image_width)   bad = {bad, " image_width"};
            if (got.image_height !== want.image_height) bad = {bad, " image_height"};
            if (got.error_code !== want.error_code)     bad = {bad, " error_code"};
            if (got.image_done !== want.image_done)     bad = {bad, " image_done"};
            if (bad != "")
                flag_fail($sformatf("tb: mismatch in%s: want %s got %s",
                                    bad, show(want), show(got)));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    logic        out_stall = 1'b0;

    tga_result_board board;
    logic [7:0]      file_bytes [$];  // the file being built, sent in order
    int              bytes_used = 0;  // bytes the decoder has taken so far
    int              burst_left = 0;
    int              idle_cycles = 0;
    t_stall_mode     stall_mode = STALL_NONE;
    int              stall_hold = 0;

    always #5 clk = ~clk;

    tga_truecolor_rle_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Receiver: each stretch of cycles gets its own back-pressure style, from none
    // at all to near-constant stalling, so results queue up inside the block.
    always @(posedge clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(20, 200);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Result check and watchdog. Everything here is sampled at the clock edge, before
    // the block's registered outputs move.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Header with random filler in the unused bytes, followed by a random ID field.
    function automatic void put_header(int id_len, logic [7:0] ty, logic [15:0] w,
                                       logic [15:0] h, logic [7:0] dep, logic [7:0] flags);
        file_bytes.delete();
        repeat (18) file_bytes.push_back(8'($urandom));
        file_bytes[HB_ID_LEN]    = 8'(id_len);
        file_bytes[HB_TYPE]      = ty;
        file_bytes[HB_WIDTH_LO]  = w[7:0];
        file_bytes[HB_WIDTH_HI]  = w[15:8];
        file_bytes[HB_HEIGHT_LO] = h[7:0];
        file_bytes[HB_HEIGHT_HI] = h[15:8];
        file_bytes[HB_DEPTH]     = dep;
        file_bytes[HB_FLAGS]     = flags;
        repeat (id_len) file_bytes.push_back(8'($urandom));
    endfunction

    // Well-formed pixel data for count pixels, stopping early once the file hits cap.
    function automatic void put_pixels(bit is_rle, bit four, int unsigned count, int cap);
        int unsigned left;
        int unsigned eff;
        int unsigned npx;
        int unsigned ncomp;
        logic [6:0]  cnt;
        logic        rep;
        left  = count;
        ncomp = four ? 4 : 3;
        while (left > 0 && file_bytes.size() < cap) begin
            npx = 1;
            eff = 1;
            if (is_rle) begin
                // mostly counts that fit, now and then one that needs clipping
                if ($urandom_range(0, 7) == 0) cnt = 7'($urandom_range(0, 127));
                else cnt = 7'($urandom_range(0, (left < 8) ? left - 1 : 7));
                rep = 1'($urandom_range(0, 1));
                eff = (cnt + 1 < left) ? cnt + 1 : left;
                npx = rep ? 1 : eff;
                file_bytes.push_back({rep, cnt});
            end
            for (int k = 0; k < npx * ncomp && file_bytes.size() < cap; k++)
                file_bytes.push_back(8'($urandom));
            left = left - eff;
        end
    endfunction

    // Mostly valid small images; some bad headers, huge sizes, cut files, trailing bytes.
    function automatic void make_random_file();
        int          pick;
        int          id_len;
        int          cut;
        logic [7:0]  ty;
        logic [7:0]  dep;
        logic [15:0] w;
        logic [15:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 45) ty = TYPE_RAW;
        else if (pick < 90) ty = TYPE_RLE;
        else ty = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) dep = DEPTH_24;
        else if (pick < 88) dep = DEPTH_32;
        else dep = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 4));
            h = (w == 0) ? 16'($urandom_range(0, 4)) : 16'd0;
        end else if (pick < 10) begin
            w = 16'($urandom);
            h = 16'($urandom_range(1, 3));
        end else if (pick < 14) begin
            w = 16'($urandom_range(1, 3));
            h = 16'($urandom);
        end else begin
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 5));
        end
        id_len = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 8);
        put_header(id_len, ty, w, h, dep, 8'($urandom));
        put_pixels(ty == TYPE_RLE, dep == DEPTH_32, {16'h0000, w} * {16'h0000, h},
                   file_bytes.size() + 160);
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
        end else if (pick < 4) begin
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
        end
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic drive_byte(input t_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_used++;
        board.note_byte(item);
    endtask

    // Sender pacing: bursts of random length, each opened by a random gap (often none).
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // last_byte goes out with the final byte of the built file.
    task automatic send_file();
        t_in item;
        foreach (file_bytes[i]) begin
            pace_sender();
            item.byte_value = file_bytes[i];
            item.last_byte  = (i == file_bytes.size() - 1);
            drive_byte(item);
        end
    endtask

    task automatic send_directed();
        // file ends after five header bytes
        put_header(0, TYPE_RAW, 16'd1, 16'd1, DEPTH_24, 8'h00);
        while (file_bytes.size() > 5) file_bytes.delete(file_bytes.size() - 1);
        send_file();
        // unsupported image type; the following bytes are ignored
        put_header(0, 8'd1, 16'd2, 16'd2, DEPTH_24, 8'h00);
        file_bytes.push_back(8'h55);
        file_bytes.push_back(8'hAA);
        send_file();
        // unsupported depth
        put_header(0, TYPE_RLE, 16'd1, 16'd1, 8'd16, 8'h00);
        file_bytes.push_back(8'h00);
        send_file();
        // zero width
        put_header(0, TYPE_RAW, 16'd0, 16'd3, DEPTH_32, 8'h00);
        file_bytes.push_back(8'hFF);
        send_file();
        // longest ID field, raw 32-bit pixels at both color extremes, both flips set
        put_header(255, TYPE_RAW, 16'd2, 16'd1, DEPTH_32, 8'h30);
        repeat (4) file_bytes.push_back(8'h00);
        repeat (4) file_bytes.push_back(8'hFF);
        send_file();
        // 128-pixel repeat clipped to a 2x2 image, wrapping a row, then a spare byte
        put_header(0, TYPE_RLE, 16'd2, 16'd2, DEPTH_24, 8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h12);
        file_bytes.push_back(8'h34);
        file_bytes.push_back(8'h56);
        file_bytes.push_back(8'h99);
        send_file();
        // literal packet cut off inside its second pixel
        put_header(0, TYPE_RLE, 16'd3, 16'd1, DEPTH_32, 8'h10);
        file_bytes.push_back(8'h02);
        repeat (6) file_bytes.push_back(8'($urandom));
        send_file();
        // largest image: one full run, then the file ends on a packet byte
        put_header(0, TYPE_RLE, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'h20);
        file_bytes.push_back(8'hFF);
        repeat (4) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(8'h00);
        send_file();
        // one-column image: each run spans many rows
        put_header(0, TYPE_RLE, 16'd1, 16'd200, DEPTH_24, 8'h00);
        file_bytes.push_back(8'hFF);
        repeat (3) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(8'hC7);
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file();
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_directed();
        while (bytes_used < RANDOM_BYTES) begin
            make_random_file();
            send_file();
        end
        in_valid <= 1'b0;
        // every owed result must show up; the watchdog catches one that never does
        while (board.results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
